// ===== rtl/bisr_pkg.sv =====
// ----------------------------------------------------------------------------
// bisr_pkg
// Shared types, codes and the microprogram of the bisection root finder.
// ----------------------------------------------------------------------------
package bisr_pkg;

  // fixed field widths
  localparam int unsigned VALUE_W   = 24;
  localparam int unsigned CAP_W     = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned UPC_W     = 5;

  localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(64);

  typedef logic signed [VALUE_W-1:0] value_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_SQUARE   = 3'd0,
    CFG_COEF_LINEAR   = 3'd1,
    CFG_COEF_CONSTANT = 3'd2,
    CFG_TOLERANCE     = 3'd3,
    CFG_ITERATION_CAP = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OUTCOME_CONVERGED = 2'd0,
    OUTCOME_INVALID   = 2'd1,
    OUTCOME_CAP       = 2'd2
  } outcome_e;

  typedef struct packed {
    value_t interval_low;
    value_t interval_high;
  } in_t;

  typedef struct packed {
    value_t             root_estimate;
    logic [CAP_W-1:0]   halvings_done;
    outcome_e           outcome;
  } out_t;

  typedef struct packed {
    value_t               coef_square;
    value_t               coef_linear;
    value_t               coef_constant;
    logic [VALUE_W-2:0]   tolerance;
    logic [CAP_W-1:0]     iteration_cap;
  } cfg_t;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE  = 3'd0,
    MUL_XX    = 3'd1,
    MUL_SQ_LO = 3'd2,
    MUL_SQ_HI = 3'd3,
    MUL_LIN   = 3'd4
  } mul_op_e;

  // accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD  = 2'd0,
    ACC_LOAD  = 2'd1,
    ACC_ADD_W = 2'd2,
    ACC_ADD_F = 2'd3
  } acc_op_e;

  // bookkeeping action of a step
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_ACCEPT  = 3'd1,
    ACT_SAVE_LO = 3'd2,
    ACT_CHECK   = 3'd3,
    ACT_BISECT  = 3'd4
  } act_e;

  // sequencing of a step
  typedef enum logic [1:0] {
    JMP_NEXT = 2'd0,
    JMP_IN   = 2'd1,
    JMP_END  = 2'd2
  } jmp_e;

  typedef struct packed {
    mul_op_e          mul_op;
    acc_op_e          acc_op;
    act_e             act;
    jmp_e             jmp;
    logic [UPC_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic in_fire;
    logic done;
    logic out_busy;
  } status_t;

  // microprogram layout
  localparam int U_IDLE     = 0;
  localparam int U_EVAL_LO  = 1;
  localparam int U_SAVE_LO  = 6;
  localparam int U_EVAL_HI  = 7;
  localparam int U_CHECK    = 12;
  localparam int U_EVAL_MID = 13;
  localparam int U_BISECT   = 18;
  localparam int U_LEN      = 19;

  // offsets inside one polynomial evaluation
  localparam int E_XX    = 0;
  localparam int E_SQ_LO = 1;
  localparam int E_SQ_HI = 2;
  localparam int E_LIN   = 3;
  localparam int E_ADD_F = 4;
  localparam int E_LEN   = 5;

  // control store
  function automatic ctl_t ucode(input logic [UPC_W-1:0] addr);
    ctl_t w;
    int   a;
    int   e;
    a        = int'(addr);
    w.mul_op = MUL_NONE;
    w.acc_op = ACC_HOLD;
    w.act    = ACT_NONE;
    w.jmp    = JMP_NEXT;
    w.target = UPC_W'(U_IDLE);
    if (a >= U_EVAL_LO && a < U_EVAL_LO + E_LEN) begin
      e = a - U_EVAL_LO;
    end else if (a >= U_EVAL_HI && a < U_EVAL_HI + E_LEN) begin
      e = a - U_EVAL_HI;
    end else if (a >= U_EVAL_MID && a < U_EVAL_MID + E_LEN) begin
      e = a - U_EVAL_MID;
    end else begin
      e = -1;
    end
    // f(x) = (xx_lo*c2 + c0<<2F) + (xx_hi*c2)<<W + (x*c1)<<F
    unique case (e)
      E_XX:    w.mul_op = MUL_XX;
      E_SQ_LO: w.mul_op = MUL_SQ_LO;
      E_SQ_HI: begin
        w.mul_op = MUL_SQ_HI;
        w.acc_op = ACC_LOAD;
      end
      E_LIN: begin
        w.mul_op = MUL_LIN;
        w.acc_op = ACC_ADD_W;
      end
      E_ADD_F: w.acc_op = ACC_ADD_F;
      default: ;
    endcase
    unique case (a)
      U_IDLE: begin
        w.act = ACT_ACCEPT;
        w.jmp = JMP_IN;
      end
      U_SAVE_LO: w.act = ACT_SAVE_LO;
      U_CHECK: begin
        w.act    = ACT_CHECK;
        w.jmp    = JMP_END;
        w.target = UPC_W'(U_EVAL_MID);
      end
      U_BISECT: begin
        w.act    = ACT_BISECT;
        w.jmp    = JMP_END;
        w.target = UPC_W'(U_EVAL_MID);
      end
      default: begin
        if (a >= U_LEN) w.jmp = JMP_END;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/bisr_cfg.sv =====
// ----------------------------------------------------------------------------
// bisr_cfg
// Configuration register file: polynomial coefficients, tolerance and cap.
// ----------------------------------------------------------------------------
module bisr_cfg #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bisr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bisr_pkg::VALUE_W-1:0]    cfg_data_i,
  output bisr_pkg::cfg_t                  cfg_o
);

  localparam int unsigned W = bisr_pkg::VALUE_W;

  // reset polynomial 1, -4, 3 and a tolerance of about 0.0001
  localparam logic signed [63:0] SQ_RST  = 64'sd1 <<< FRACTION_BITS;
  localparam logic signed [63:0] LIN_RST = -(64'sd4 <<< FRACTION_BITS);
  localparam logic signed [63:0] CON_RST = 64'sd3 <<< FRACTION_BITS;
  localparam logic [63:0] TOL_RST = ((64'd1 << FRACTION_BITS) + 64'd5000) / 64'd10000;

  bisr_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (bisr_pkg::cfg_idx_e'(cfg_index_i))
        bisr_pkg::CFG_COEF_SQUARE:   cfg_d.coef_square   = cfg_data_i;
        bisr_pkg::CFG_COEF_LINEAR:   cfg_d.coef_linear   = cfg_data_i;
        bisr_pkg::CFG_COEF_CONSTANT: cfg_d.coef_constant = cfg_data_i;
        bisr_pkg::CFG_TOLERANCE:     cfg_d.tolerance     = cfg_data_i[W-2:0];
        bisr_pkg::CFG_ITERATION_CAP:
          cfg_d.iteration_cap = cfg_data_i[bisr_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_square   <= SQ_RST[W-1:0];
      cfg_q.coef_linear   <= LIN_RST[W-1:0];
      cfg_q.coef_constant <= CON_RST[W-1:0];
      cfg_q.tolerance     <= TOL_RST[W-2:0];
      cfg_q.iteration_cap <= bisr_pkg::CAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/bisr_sequencer.sv =====
// ----------------------------------------------------------------------------
// bisr_sequencer
// Microprogram counter with conditional jumps; fetches one control word a step.
// ----------------------------------------------------------------------------
module bisr_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bisr_pkg::status_t  status_i,
  output bisr_pkg::ctl_t     ctl_o
);

  localparam int unsigned UW = bisr_pkg::UPC_W;

  logic [UW-1:0]  upc_q, upc_d;
  bisr_pkg::ctl_t ctl;

  // control store fetch
  assign ctl   = bisr_pkg::ucode(upc_q);
  assign ctl_o = ctl;

  // next step selection
  always_comb begin
    unique case (ctl.jmp)
      bisr_pkg::JMP_NEXT: upc_d = upc_q + UW'(1);
      bisr_pkg::JMP_IN:   upc_d = status_i.in_fire ? upc_q + UW'(1) : upc_q;
      bisr_pkg::JMP_END: begin
        priority if (status_i.done && status_i.out_busy) begin
          upc_d = upc_q;
        end else if (status_i.done) begin
          upc_d = UW'(bisr_pkg::U_IDLE);
        end else begin
          upc_d = ctl.target;
        end
      end
      default: upc_d = UW'(bisr_pkg::U_IDLE);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UW'(bisr_pkg::U_IDLE);
    end else begin
      upc_q <= upc_d;
    end
  end

  // program counter stays inside the control store
  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(upc_q) < bisr_pkg::U_LEN)
    else $error("microprogram counter out of range");

  // a finished item waiting on a busy output keeps its step
  a_hold_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.jmp == bisr_pkg::JMP_END) && status_i.done && status_i.out_busy
    |=> $stable(upc_q))
    else $error("step left while result could not be stored");

  // an accepted request starts evaluation at the low end
  a_start_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.in_fire |=> (int'(upc_q) == bisr_pkg::U_EVAL_LO))
    else $error("request did not start evaluation");

endmodule

// ===== rtl/bisr_datapath.sv =====
// ----------------------------------------------------------------------------
// bisr_datapath
// Interval registers, shared multiplier, wide accumulator and result register.
// ----------------------------------------------------------------------------
module bisr_datapath #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bisr_pkg::cfg_t     cfg_i,
  input  bisr_pkg::ctl_t     ctl_i,
  output bisr_pkg::status_t  status_o,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bisr_pkg::in_t      in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bisr_pkg::out_t     out_data_o
);

  localparam int unsigned W     = bisr_pkg::VALUE_W;
  localparam int unsigned F     = FRACTION_BITS;
  localparam int unsigned CW    = bisr_pkg::CAP_W;
  localparam int unsigned T_SQ  = 3 * W;
  localparam int unsigned T_LIN = 2 * W + F;
  localparam int unsigned T_CON = W + 2 * F;
  localparam int unsigned T_MAX = (T_SQ > T_LIN) ? T_SQ : T_LIN;
  localparam int unsigned ACC_W = ((T_MAX > T_CON) ? T_MAX : T_CON) + 3;

  function automatic bisr_pkg::value_t midpoint(input bisr_pkg::value_t a,
                                                input bisr_pkg::value_t b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    return s[W:1];
  endfunction

  bisr_pkg::value_t          lo_q, lo_d, hi_q, hi_d, x_q, x_d;
  logic signed [2*W-1:0]     xx_q;
  logic signed [2*W:0]       p_q, prod;
  logic signed [W:0]         mul_a;
  logic signed [W-1:0]       mul_b;
  logic signed [ACC_W-1:0]   acc_q, acc_d, p_ext, c0_ext;
  logic [ACC_W-1:0]          acc_bits, acc_inv, tol_wide;
  logic                      slo_zero_q, slo_zero_d, slo_neg_q, slo_neg_d;
  logic [CW-1:0]             count_q, count_d;
  logic                      out_valid_q, out_valid_d;
  bisr_pkg::out_t            out_q, result;
  logic                      in_fire, acc_zero, acc_neg, keep_lower, invalid;
  logic                      converged, cap_hit, done, out_free, emit;
  bisr_pkg::value_t          mid_cur, mid_next, new_lo, new_hi;

  // input handshake
  assign in_stall_o = (ctl_i.act != bisr_pkg::ACT_ACCEPT);
  assign in_fire    = in_valid_i && !in_stall_o;

  // shared multiplier operand selection
  always_comb begin
    unique case (ctl_i.mul_op)
      bisr_pkg::MUL_XX: begin
        mul_a = {x_q[W-1], x_q};
        mul_b = x_q;
      end
      bisr_pkg::MUL_SQ_LO: begin
        mul_a = {1'b0, xx_q[W-1:0]};
        mul_b = cfg_i.coef_square;
      end
      bisr_pkg::MUL_SQ_HI: begin
        mul_a = {xx_q[2*W-1], xx_q[2*W-1:W]};
        mul_b = cfg_i.coef_square;
      end
      bisr_pkg::MUL_LIN: begin
        mul_a = {x_q[W-1], x_q};
        mul_b = cfg_i.coef_linear;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // accumulator of the polynomial terms
  assign p_ext  = ACC_W'(p_q);
  assign c0_ext = ACC_W'(cfg_i.coef_constant) <<< (2 * F);

  always_comb begin
    unique case (ctl_i.acc_op)
      bisr_pkg::ACC_LOAD:  acc_d = p_ext + c0_ext;
      bisr_pkg::ACC_ADD_W: acc_d = acc_q + (p_ext <<< W);
      bisr_pkg::ACC_ADD_F: acc_d = acc_q + (p_ext <<< F);
      default:             acc_d = acc_q;
    endcase
  end

  // sign and tolerance tests on f
  assign acc_zero = (acc_q == '0);
  assign acc_neg  = acc_q[ACC_W-1];
  assign acc_bits = acc_q;
  assign acc_inv  = ~acc_bits;
  assign tol_wide = ACC_W'(cfg_i.tolerance) << (2 * F);
  // for negative f, |f| <= tol is the same as ~f < tol
  assign converged = acc_neg ? (acc_inv < tol_wide) : (acc_bits <= tol_wide);
  assign cap_hit   = (count_q >= cfg_i.iteration_cap);
  assign invalid   = !slo_zero_q && !acc_zero && (slo_neg_q == acc_neg);
  assign keep_lower = !slo_zero_q && !acc_zero && (slo_neg_q != acc_neg);

  // next interval and its midpoint
  assign mid_cur  = midpoint(lo_q, hi_q);
  assign new_lo   = keep_lower ? lo_q : x_q;
  assign new_hi   = keep_lower ? x_q : hi_q;
  assign mid_next = midpoint(new_lo, new_hi);

  // end of item and result word
  always_comb begin
    done   = 1'b0;
    result = '{root_estimate: '0, halvings_done: '0,
               outcome: bisr_pkg::OUTCOME_INVALID};
    unique case (ctl_i.act)
      bisr_pkg::ACT_CHECK: done = invalid;
      bisr_pkg::ACT_BISECT: begin
        done                 = converged || cap_hit;
        result.root_estimate = x_q;
        result.halvings_done = count_q;
        result.outcome       = converged ? bisr_pkg::OUTCOME_CONVERGED
                                         : bisr_pkg::OUTCOME_CAP;
      end
      default: ;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = done && out_free;

  // interval, evaluation point and sign bookkeeping
  always_comb begin
    lo_d       = lo_q;
    hi_d       = hi_q;
    x_d        = x_q;
    slo_zero_d = slo_zero_q;
    slo_neg_d  = slo_neg_q;
    count_d    = count_q;
    unique case (ctl_i.act)
      bisr_pkg::ACT_ACCEPT: begin
        if (in_fire) begin
          lo_d    = in_data_i.interval_low;
          hi_d    = in_data_i.interval_high;
          x_d     = in_data_i.interval_low;
          count_d = '0;
        end
      end
      bisr_pkg::ACT_SAVE_LO: begin
        slo_zero_d = acc_zero;
        slo_neg_d  = acc_neg;
        x_d        = hi_q;
      end
      bisr_pkg::ACT_CHECK: begin
        if (!invalid) x_d = mid_cur;
      end
      bisr_pkg::ACT_BISECT: begin
        if (!done) begin
          lo_d    = new_lo;
          hi_d    = new_hi;
          x_d     = mid_next;
          count_d = count_q + CW'(1);
          if (!keep_lower) begin
            slo_zero_d = acc_zero;
            slo_neg_d  = acc_neg;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    x_q        <= x_d;
    slo_zero_q <= slo_zero_d;
    slo_neg_q  <= slo_neg_d;
    count_q    <= count_d;
    acc_q      <= acc_d;
    if (ctl_i.mul_op == bisr_pkg::MUL_XX) begin
      xx_q <= prod[2*W-1:0];
    end else if (ctl_i.mul_op != bisr_pkg::MUL_NONE) begin
      p_q <= prod;
    end
    if (emit) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.in_fire  = in_fire;
  assign status_o.done     = done;
  assign status_o.out_busy = !out_free;

  // halving count never passes the cap
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.act == bisr_pkg::ACT_BISECT) |-> (count_q <= cfg_i.iteration_cap))
    else $error("halving count beyond cap");

  // the tested midpoint lies between the interval ends
  a_mid_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.act == bisr_pkg::ACT_BISECT) |->
    (((x_q >= lo_q) && (x_q <= hi_q)) || ((x_q <= lo_q) && (x_q >= hi_q))))
    else $error("midpoint outside interval");

  // a cap result always reports the full number of halvings
  a_cap_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.outcome == bisr_pkg::OUTCOME_CAP) |->
    (out_q.halvings_done == cfg_i.iteration_cap))
    else $error("cap result with wrong halving count");

endmodule

// ===== rtl/bisection_root_finder.sv =====
// ----------------------------------------------------------------------------
// bisection_root_finder
// Bisection search for a root of c2*x*x + c1*x + c0 in signed Q8.16.
// ----------------------------------------------------------------------------
// Usage: a request on the input channel (in_valid_i / in_stall_o) carries one
// search interval; the block answers with exactly one result on the output
// channel (out_valid_o / out_stall_i): final midpoint, halvings done and an
// outcome code (converged, invalid interval, cap reached). A request is taken
// when valid is high and stall is low.
// The coefficients, tolerance and iteration cap sit on a separate write port
// (cfg_valid_i / cfg_ready_o, index and data); write them only while idle.
// A microcoded sequencer drives one shared multiplier, so each polynomial
// evaluation runs as a sequence of steps: x*x, the low and high halves of
// x*x times c2, x times c1 and a final add. Both ends are evaluated first;
// for a valid interval each midpoint is then evaluated in turn. A new
// request can be taken in the cycle after a result is stored.
// Reset loads the polynomial 1, -4, 3, a tolerance of 7 LSB and a cap of 64,
// and empties the output register. A stalled result stays in the output
// register; the next item runs up to its own result and then waits for it.
// ----------------------------------------------------------------------------
module bisection_root_finder #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bisr_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bisr_pkg::out_t                  out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bisr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bisr_pkg::VALUE_W-1:0]    cfg_data_i
);

  bisr_pkg::cfg_t    cfg;
  bisr_pkg::ctl_t    ctl;
  bisr_pkg::status_t status;

  // configuration registers
  bisr_cfg #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // microprogram sequencer
  bisr_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctl_o    (ctl)
  );

  // datapath
  bisr_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .ctl_i       (ctl),
    .status_o    (status),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bisection root finder. Intervals are pushed
// through the request channel in bursts while the result side stalls on its
// own pattern. Every accepted request is solved again by a bit-exact model of
// the bisection held in a small scoreboard, and each result is compared field
// by field. Directed intervals and register settings cover the extremes and
// the corner cases, then randomized polynomials with known roots feed mostly
// bracketing intervals.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ONE             = 1 << 16;  // 1.0 in Q8.16
  localparam int FRAC            = 16;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 212;
  localparam int END_SETTLE      = 40;
  // sized for ~1.7k requests, each at worst running up to the largest cap
  localparam int unsigned CYCLE_LIMIT = 12_000_000;

  localparam logic [bisr_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  typedef logic signed [127:0] poly_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_HOLD
  } stall_mode_e;

  // --------------------------------------------------------------------------
  // scoreboard: register shadow, bisection model, queue of pending roots
  // --------------------------------------------------------------------------
  class root_scoreboard;
    bisr_pkg::cfg_t regs;
    bisr_pkg::out_t pending_roots[$];
    int   failures;
    int   checked;
    int   n_converged;
    int   n_invalid;
    int   n_capped;

    function new();
      regs.coef_square   = bisr_pkg::value_t'(ONE);
      regs.coef_linear   = bisr_pkg::value_t'(-4 * ONE);
      regs.coef_constant = bisr_pkg::value_t'(3 * ONE);
      regs.tolerance     = 23'd7;
      regs.iteration_cap = bisr_pkg::CAP_RST;
      failures    = 0;
      checked     = 0;
      n_converged = 0;
      n_invalid   = 0;
      n_capped    = 0;
    endfunction

    // register write as seen by the block, unused bits dropped
    function void apply_register(logic [bisr_pkg::CFG_IDX_W-1:0] idx,
                                 logic [bisr_pkg::VALUE_W-1:0] data);
      case (idx)
        bisr_pkg::CFG_COEF_SQUARE:   regs.coef_square   = data;
        bisr_pkg::CFG_COEF_LINEAR:   regs.coef_linear   = data;
        bisr_pkg::CFG_COEF_CONSTANT: regs.coef_constant = data;
        bisr_pkg::CFG_TOLERANCE:     regs.tolerance     = data[bisr_pkg::VALUE_W-2:0];
        bisr_pkg::CFG_ITERATION_CAP: regs.iteration_cap = data[bisr_pkg::CAP_W-1:0];
        default: ;
      endcase
    endfunction

    // f(x) scaled by 2^(3*FRAC), exact
    function poly_t poly_at(poly_t x);
      poly_t c2;
      poly_t c1;
      poly_t c0;
      c2 = $signed(regs.coef_square);
      c1 = $signed(regs.coef_linear);
      c0 = $signed(regs.coef_constant);
      return x * x * c2 + ((x * c1) <<< FRAC) + (c0 <<< (2 * FRAC));
    endfunction

    function int sign_of(poly_t v);
      if (v == 0) return 0;
      return (v < 0) ? -1 : 1;
    endfunction

    // full bisection search for one interval
    function bisr_pkg::out_t bisect_interval(bisr_pkg::in_t req);
      poly_t lo;
      poly_t hi;
      poly_t mid;
      poly_t f_mid;
      poly_t tol_scaled;
      int    s_lo;
      int    s_hi;
      int    halvings;
      bisr_pkg::out_t res;
      lo         = $signed(req.interval_low);
      hi         = $signed(req.interval_high);
      tol_scaled = regs.tolerance;
      tol_scaled = tol_scaled <<< (2 * FRAC);
      res        = '0;
      s_lo       = sign_of(poly_at(lo));
      s_hi       = sign_of(poly_at(hi));
      // both ends strictly on one side: no sign change to chase
      if (s_lo != 0 && s_lo == s_hi) begin
        res.outcome = bisr_pkg::OUTCOME_INVALID;
        return res;
      end
      halvings = 0;
      while (1'b1) begin
        mid   = (lo + hi) >>> 1;
        f_mid = poly_at(mid);
        if (((f_mid < 0) ? -f_mid : f_mid) <= tol_scaled) begin
          res.outcome = bisr_pkg::OUTCOME_CONVERGED;
          break;
        end
        if (halvings >= regs.iteration_cap) begin
          res.outcome = bisr_pkg::OUTCOME_CAP;
          break;
        end
        if (sign_of(poly_at(lo)) * sign_of(f_mid) < 0) hi = mid;
        else lo = mid;
        halvings++;
      end
      res.root_estimate = mid[bisr_pkg::VALUE_W-1:0];
      res.halvings_done = bisr_pkg::CAP_W'(halvings);
      return res;
    endfunction

    function void note_request(bisr_pkg::in_t req);
      bisr_pkg::out_t want;
      want = bisect_interval(req);
      case (want.outcome)
        bisr_pkg::OUTCOME_CONVERGED: n_converged++;
        bisr_pkg::OUTCOME_INVALID:   n_invalid++;
        default:                     n_capped++;
      endcase
      pending_roots.push_back(want);
    endfunction

    function void mismatch(string field, longint want, longint got);
      failures++;
      $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_result(bisr_pkg::out_t got);
      bisr_pkg::out_t want;
      if (pending_roots.size() == 0) begin
        failures++;
        $error("result with no request outstanding: root_estimate %0d",
               $signed(got.root_estimate));
        return;
      end
      want = pending_roots.pop_front();
      checked++;
      if (got.root_estimate !== want.root_estimate)
        mismatch("root_estimate", $signed(want.root_estimate), $signed(got.root_estimate));
      if (got.halvings_done !== want.halvings_done)
        mismatch("halvings_done", want.halvings_done, got.halvings_done);
      if (got.outcome !== want.outcome)
        mismatch("outcome", want.outcome, got.outcome);
    endfunction

    function void check_drained();
      if (pending_roots.size() != 0) begin
        failures++;
        $error("%0d results never arrived", pending_roots.size());
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic                           clk_i;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  bisr_pkg::in_t                  in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  bisr_pkg::out_t                 out_data_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [bisr_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [bisr_pkg::VALUE_W-1:0]   cfg_data_i  = '0;

  bisection_root_finder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  root_scoreboard sb;
  int unsigned    cycle_count  = 0;
  int             burst_left   = 0;
  int             settings_run = 1;
  stall_mode_e    stall_mode   = STALL_NONE;
  int             stall_span   = 0;
  logic           stall_next;

  // clock and cycle count
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("bisection_root_finder verification failed");
    $finish;
  end

  // result side: check accepted results, then pick the next stall
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (stall_span == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_span = (stall_mode == STALL_HOLD) ? $urandom_range(4, 40)
                                              : $urandom_range(8, 120);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      STALL_NONE:  stall_next = 1'b0;
      STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
      default:     stall_next = 1'b1;
    endcase
    out_stall_i <= stall_next;
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // one request, then maybe a gap once the burst is used up
  task automatic issue(input bisr_pkg::in_t req);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(req);
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_pair(input int lo, input int hi);
    bisr_pkg::in_t req;
    req.interval_low  = bisr_pkg::value_t'(lo);
    req.interval_high = bisr_pkg::value_t'(hi);
    issue(req);
  endtask

  // stop sending and wait for every result to come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_roots.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bisr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bisr_pkg::VALUE_W-1:0] data,
                           input bit drop_valid);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.apply_register(idx, data);
    if (drop_valid) cfg_valid_i <= 1'b0;
  endtask

  // all five registers, unused upper bits of tolerance and cap randomized
  task automatic load_config(input bisr_pkg::cfg_t c);
    write_reg(bisr_pkg::CFG_COEF_SQUARE, c.coef_square, 1'b0);
    write_reg(bisr_pkg::CFG_COEF_LINEAR, c.coef_linear, 1'b0);
    write_reg(bisr_pkg::CFG_COEF_CONSTANT, c.coef_constant, 1'b0);
    write_reg(bisr_pkg::CFG_TOLERANCE, {1'($urandom_range(0, 1)), c.tolerance}, 1'b0);
    write_reg(bisr_pkg::CFG_ITERATION_CAP, {16'($urandom), c.iteration_cap}, 1'b1);
    settings_run++;
  endtask

  function automatic bisr_pkg::cfg_t make_cfg(int c2, int c1, int c0, int tol, int cap);
    bisr_pkg::cfg_t c;
    c.coef_square   = bisr_pkg::value_t'(c2);
    c.coef_linear   = bisr_pkg::value_t'(c1);
    c.coef_constant = bisr_pkg::value_t'(c0);
    c.tolerance     = 23'(tol);
    c.iteration_cap = bisr_pkg::CAP_W'(cap);
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    bisr_pkg::in_t req;
    int  c2;
    int  c1;
    int  c0;
    int  tol;
    int  cap;
    int  ra;
    int  rb;
    int  lo;
    int  hi;
    int  r;
    int  tmp;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset polynomial x^2 - 4x + 3, roots at 1 and 3
    send_pair(0, 2 * ONE);
    send_pair(2 * ONE, 4 * ONE);
    send_pair(4 * ONE, 2 * ONE);                  // reversed ends
    send_pair(ONE, 3 * ONE);                      // both ends are roots
    send_pair(5 * ONE, 6 * ONE);                  // same sign at both ends
    send_pair(-8388608, 8388607);
    send_pair(8388607, -8388608);
    send_pair(-8388608, -8388608);
    send_pair(8388607, 8388607);
    send_pair(ONE, ONE);                          // degenerate interval on a root
    send_pair(2 * ONE, 8388607);
    send_pair(-8388608, 2 * ONE);
    send_pair(-1, 2 * ONE + 1);                   // even sum, midpoint on the root at 1
    drain();

    // zero cap: first midpoint on a root, then one that is not
    load_config(make_cfg(ONE, -4 * ONE, 3 * ONE, 7, 0));
    send_pair(0, 2 * ONE);
    send_pair(0, 3 * ONE);
    drain();

    // widest tolerance (top data bit must be dropped) and largest cap
    write_reg(bisr_pkg::CFG_TOLERANCE, 24'hFFFFFF, 1'b0);
    write_reg(bisr_pkg::CFG_ITERATION_CAP, 24'd255, 1'b1);
    send_pair(2 * ONE, 8388607);
    drain();

    // irrational roots with zero tolerance run into the largest cap
    load_config(make_cfg(ONE, 0, -2 * ONE, 0, 255));
    send_pair(0, 2 * ONE);
    send_pair(-8388608, 0);
    drain();

    // coefficient extremes
    load_config(make_cfg(-8388608, 8388607, -8388608, 1, 64));
    send_pair(-8388608, 8388607);
    send_pair(0, 8388607);
    send_pair(8388607, -8388608);
    drain();
    load_config(make_cfg(8388607, -8388608, 8388607, 0, 64));
    send_pair(0, ONE);
    send_pair(-8388608, 8388607);
    drain();

    // zero polynomial, then a write to an unmapped index that must do nothing
    load_config(make_cfg(0, 0, 0, 0, 1));
    write_reg(CFG_UNMAPPED, 24'hFFFFFF, 1'b1);
    send_pair(-8388608, 8388607);
    drain();

    // random register settings, mostly quadratics with known roots
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      ra = int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
      if ($urandom_range(0, 9) < 7) begin
        rb = int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
        c2 = int'($urandom_range(ONE / 4, 4 * ONE));
        if ($urandom_range(0, 1) != 0) c2 = -c2;
        c1 = int'(-((longint'(c2) * (ra + rb)) >>> FRAC));
        c0 = int'((longint'(c2) * ra * rb) >>> (2 * FRAC));
      end else begin
        rb = -ra;
        c2 = $urandom;
        c1 = $urandom;
        c0 = $urandom;
      end
      case ($urandom_range(0, 3))
        0:       tol = 0;
        3:       tol = $urandom;
        default: tol = $urandom_range(0, 64);
      endcase
      cap = ($urandom_range(0, 19) < 3) ? $urandom_range(0, 3) : $urandom_range(8, 64);
      load_config(make_cfg(c2, c1, c0, tol, cap));

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            // anywhere in the number range
            lo = $urandom;
            hi = $urandom;
          end
          2, 3, 4: begin
            lo = int'($urandom_range(0, 12 * ONE)) - 6 * ONE;
            hi = int'($urandom_range(0, 12 * ONE)) - 6 * ONE;
          end
          default: begin
            // around one root, usually bracketing it
            r  = ($urandom_range(0, 1) != 0) ? ra : rb;
            lo = r - int'($urandom_range(0, ONE));
            hi = r + int'($urandom_range(0, ONE));
            if ($urandom_range(0, 1) != 0) begin
              tmp = lo;
              lo  = hi;
              hi  = tmp;
            end
          end
        endcase
        req.interval_low  = bisr_pkg::value_t'(lo);
        req.interval_high = bisr_pkg::value_t'(hi);
        issue(req);
      end
      drain();
    end

    repeat (END_SETTLE) @(posedge clk_i);
    sb.check_drained();
    $display("checked %0d search intervals over %0d register settings",
             sb.checked, settings_run);
    $display("%0d converged, %0d rejected as invalid, %0d stopped at the halving cap",
             sb.n_converged, sb.n_invalid, sb.n_capped);
    if (sb.failures == 0) begin
      $display("bisection_root_finder verification clean");
    end else begin
      $display("bisection_root_finder verification failed");
    end
    $finish;
  end

endmodule
